/* hw/rtl/ipcg_pkg.sv */
package ipcg_pkg;

    // default fixed-point position format
    localparam int POS_FRAC_BITS_DEF = 10;

    // register indexes
    localparam logic [7:0] REG_SPACING_X = 8'd0;
    localparam logic [7:0] REG_SPACING_Y = 8'd1;
    localparam logic [7:0] REG_COLUMNS   = 8'd2;
    localparam logic [7:0] REG_ROWS      = 8'd3;

    // register reset values
    localparam logic [20:0] SPACING_RST = 21'd65536;
    localparam logic [15:0] PIXELS_RST  = 16'd256;

    // result kinds
    localparam logic [2:0] KIND_TLC    = 3'd0;
    localparam logic [2:0] KIND_TRC    = 3'd1;
    localparam logic [2:0] KIND_BLC    = 3'd2;
    localparam logic [2:0] KIND_BRC    = 3'd3;
    localparam logic [2:0] KIND_NORMAL = 3'd4;

    // internal widths
    localparam int TLC_W  = 33;
    localparam int CR_W   = 33;
    localparam int SQ_W   = 63;
    localparam int ACC_W  = 50;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // configuration registers
    typedef struct packed {
        logic [20:0] spacing_x;
        logic [20:0] spacing_y;
        logic [15:0] columns;
        logic [15:0] rows;
    } t_cfg;

    // one classified item between front and back
    typedef struct packed {
        logic [3:0][2:0][31:0]      corner;
        logic [2:0][TLC_W-1:0]      tlc;
        logic [2:0][CR_W-1:0]       cr;
        logic [2:0][SQ_W-1:0]       sq;
        logic                       fov_zero;
    } t_qent;

    // arithmetic right shift rounding to nearest, ties away from zero
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned s);
        logic signed [63:0] h;
        logic signed [63:0] t;
        h = 64'sd1 <<< (s - 1);
        t = v + h - $signed({63'd0, v[63]});
        return t >>> s;
    endfunction

    // saturate to signed 32 bits
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

/* hw/rtl/image_plane_corner_geometry_core.sv */
// image plane corner geometry
//
// slave stream: one transfer per image plane carrying the first voxel centre
// and the row and column direction cosines. master stream: five transfers per
// input, top-left, top-right, bottom-left and bottom-right corners, then the
// unit normal with the plane offset, which carries tlast.
// config channel: index 0 spacing_x, 1 spacing_y, 2 columns, 3 rows; other
// indexes are ignored; always ready, write only while the block is idle.
// the slave side holds tready low for one cycle after a register write that changes a value.
// the four corners are sent while the back end works out the normal. the
// back end takes the next item once the normal is sent; a 32-step square root
// and a 15-step divider run on the normal of each item that is not degenerate.
// up to four items are held between the slave side and the back end.
// reset: synchronous, active low; registers return to 1 mm spacing and a
// 256 x 256 image, the queue empties.
// a stalled master side holds its transfer; the queue then fills and
// the slave side drops tready.
module image_plane_corner_geometry_core #(
    parameter int POS_FRAC_BITS = ipcg_pkg::POS_FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // position_x, position_y, position_z, row_cos_x, row_cos_y, row_cos_z,
    // col_cos_x, col_cos_y, col_cos_z
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [191:0] i_s_tdata,
    // out_x, out_y, out_z, plane_offset
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [127:0] o_m_tdata,
    // point_kind, degenerate
    output logic [3:0]   o_m_tuser,
    output logic         o_m_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    ipcg_pkg::t_cfg  r_cfg;
    logic            w_push, w_pop, w_qvalid;
    ipcg_pkg::t_qent w_fent, w_qent;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spacing_x <= ipcg_pkg::SPACING_RST;
            r_cfg.spacing_y <= ipcg_pkg::SPACING_RST;
            r_cfg.columns   <= ipcg_pkg::PIXELS_RST;
            r_cfg.rows      <= ipcg_pkg::PIXELS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ipcg_pkg::REG_SPACING_X: r_cfg.spacing_x <= i_cfg_data[20:0];
                ipcg_pkg::REG_SPACING_Y: r_cfg.spacing_y <= i_cfg_data[20:0];
                ipcg_pkg::REG_COLUMNS:   r_cfg.columns   <= i_cfg_data[15:0];
                ipcg_pkg::REG_ROWS:      r_cfg.rows      <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    ipcg_front #(
        .POS_FRAC_BITS(POS_FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_push     (w_push),
        .o_ent      (w_fent),
        .i_pop      (w_pop)
    );

    ipcg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ent   (w_fent),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_ent   (w_qent)
    );

    ipcg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_qvalid),
        .i_ent      (w_qent),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

/* hw/rtl/ipcg_front.sv */
module ipcg_front #(
    parameter int POS_FRAC_BITS = ipcg_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ipcg_pkg::t_cfg       i_cfg,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [191:0]         i_s_tdata,
    output logic                 o_push,
    output ipcg_pkg::t_qent      o_ent,
    input  logic                 i_pop
);

    localparam int HALF_SH = 31 - POS_FRAC_BITS;
    localparam int SIDE_SH = 30 - POS_FRAC_BITS;
    localparam int AX_W    = 25 + POS_FRAC_BITS;
    localparam int CW      = ((AX_W > ipcg_pkg::TLC_W) ? AX_W : ipcg_pkg::TLC_W) + 2;
    localparam int TW      = ipcg_pkg::TLC_W;

    logic [36:0]                 r_fovx, r_fovy;
    ipcg_pkg::t_cfg              r_cfg_q;
    logic                        w_cfg_ok;
    logic [ipcg_pkg::QCNT_W-1:0] r_pend, n_pend;
    logic                        w_acc;
    logic                        r_s1_v, r_s2_v, r_s3_v;
    logic                        r_s1_fz, r_s2_fz;

    logic signed [15:0]          w_rc [3];
    logic signed [15:0]          w_cc [3];
    logic signed [16:0]          w_rsum [3];

    logic signed [31:0]          r_pos [3];
    logic signed [38:0]          r_ph [3];
    logic signed [53:0]          r_pax [3];
    logic signed [53:0]          r_pay [3];
    logic signed [31:0]          r_pa [3];
    logic signed [31:0]          r_pb [3];

    logic signed [TW-1:0]        r_tlc [3];
    logic signed [AX_W-1:0]      r_ax [3];
    logic signed [AX_W-1:0]      r_ay [3];
    logic signed [ipcg_pkg::CR_W-1:0] r_cr [3];

    logic signed [CW-1:0]        w_c1 [3];
    logic signed [CW-1:0]        w_c2 [3];
    logic signed [CW-1:0]        w_c3 [3];
    logic signed [65:0]          w_sq [3];
    ipcg_pkg::t_qent             r_ent;

    // field of view from the geometry registers, with the settings it was built from
    always_ff @(posedge i_clk) begin
        r_fovx  <= 37'(i_cfg.columns) * 37'(i_cfg.spacing_x);
        r_fovy  <= 37'(i_cfg.rows) * 37'(i_cfg.spacing_y);
        r_cfg_q <= i_cfg;
    end

    // field of view is current once it matches the registers
    assign w_cfg_ok = (r_cfg_q == i_cfg);

    // items in flight between input and back end release
    assign o_s_tready = (r_pend < ipcg_pkg::QCNT_W'(ipcg_pkg::QDEPTH)) && w_cfg_ok;
    assign w_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        n_pend = r_pend + ipcg_pkg::QCNT_W'(w_acc) - ipcg_pkg::QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_pend <= n_pend;
            r_s1_v <= w_acc;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    // unpack cosines
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rc[i]   = $signed(i_s_tdata[96 + 16*i +: 16]);
            w_cc[i]   = $signed(i_s_tdata[144 + 16*i +: 16]);
            w_rsum[i] = 17'(w_rc[i]) + 17'(w_cc[i]);
        end
    end

    // stage 1: products
    always_ff @(posedge i_clk) begin
        r_s1_fz <= (r_fovx == '0) || (r_fovy == '0);
        for (int i = 0; i < 3; i++) begin
            r_pos[i] <= $signed(i_s_tdata[32*i +: 32]);
            r_ph[i]  <= $signed({1'b0, i_cfg.spacing_x}) * w_rsum[i];
            r_pax[i] <= $signed({1'b0, r_fovx}) * w_rc[i];
            r_pay[i] <= $signed({1'b0, r_fovy}) * w_cc[i];
        end
        r_pa[0] <= w_rc[1] * w_cc[2];
        r_pb[0] <= w_rc[2] * w_cc[1];
        r_pa[1] <= w_rc[2] * w_cc[0];
        r_pb[1] <= w_rc[0] * w_cc[2];
        r_pa[2] <= w_rc[0] * w_cc[1];
        r_pb[2] <= w_rc[1] * w_cc[0];
    end

    // stage 2: rescale, corner edge and cross product
    always_ff @(posedge i_clk) begin
        r_s2_fz <= r_s1_fz;
        for (int i = 0; i < 3; i++) begin
            r_tlc[i] <= TW'(r_pos[i]) - TW'(ipcg_pkg::rnd_shift(64'(r_ph[i]), HALF_SH));
            r_ax[i]  <= AX_W'(ipcg_pkg::rnd_shift(64'(r_pax[i]), SIDE_SH));
            r_ay[i]  <= AX_W'(ipcg_pkg::rnd_shift(64'(r_pay[i]), SIDE_SH));
            r_cr[i]  <= ipcg_pkg::CR_W'(r_pa[i]) - ipcg_pkg::CR_W'(r_pb[i]);
        end
    end

    // stage 3: corners and squared cross terms
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_c1[i] = CW'(r_tlc[i]) + CW'(r_ax[i]);
            w_c2[i] = CW'(r_tlc[i]) + CW'(r_ay[i]);
            w_c3[i] = w_c2[i] + CW'(r_ax[i]);
            w_sq[i] = 66'(r_cr[i]) * 66'(r_cr[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent.fov_zero <= r_s2_fz;
        for (int i = 0; i < 3; i++) begin
            r_ent.corner[0][i] <= ipcg_pkg::sat32(64'(r_tlc[i]));
            r_ent.corner[1][i] <= ipcg_pkg::sat32(64'(w_c1[i]));
            r_ent.corner[2][i] <= ipcg_pkg::sat32(64'(w_c2[i]));
            r_ent.corner[3][i] <= ipcg_pkg::sat32(64'(w_c3[i]));
            r_ent.tlc[i]       <= r_tlc[i];
            r_ent.cr[i]        <= r_cr[i];
            r_ent.sq[i]        <= w_sq[i][ipcg_pkg::SQ_W-1:0];
        end
    end

    assign o_push = r_s3_v;
    assign o_ent  = r_ent;

endmodule

/* hw/rtl/ipcg_fifo.sv */
module ipcg_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ipcg_pkg::t_qent  i_ent,
    input  logic             i_pop,
    output logic             o_valid,
    output ipcg_pkg::t_qent  o_ent
);

    ipcg_pkg::t_qent             r_mem [ipcg_pkg::QDEPTH];
    logic [ipcg_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [ipcg_pkg::QCNT_W-1:0] r_cnt;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + ipcg_pkg::QCNT_W'(i_push) - ipcg_pkg::QCNT_W'(i_pop);
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_mem[r_rp];

endmodule

/* hw/rtl/ipcg_back.sv */
module ipcg_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ipcg_pkg::t_qent  i_ent,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [127:0]     o_m_tdata,
    output logic [3:0]       o_m_tuser,
    output logic             o_m_tlast
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SUM  = 6'b000010,
        ST_SQRT = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_DOT  = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    t_state              r_st;
    logic [63:0]         r_x, r_r, r_b;
    logic [4:0]          r_cnt;
    logic [31:0]         r_len;
    logic [32:0]         r_rem [3];
    logic [14:0]         r_num [3];
    logic [14:0]         r_q [3];
    logic signed [15:0]  r_n [3];
    logic signed [ipcg_pkg::ACC_W-1:0] r_acc;
    logic [1:0]          r_dcnt;
    logic                r_deg;
    logic [2:0]          r_emit;

    logic                r_ov;
    logic [2:0]          r_kind;
    logic [31:0]         r_ox, r_oy, r_oz, r_ooff;
    logic                r_odeg, r_olast;

    logic [63:0]         w_s2, w_rb, w_rn;
    logic                w_ge;
    logic [31:0]         w_abs [3];
    logic [46:0]         w_num [3];
    logic [33:0]         w_t [3];
    logic                w_dge [3];
    logic [14:0]         w_qf [3];
    logic signed [ipcg_pkg::ACC_W-1:0] w_prod;
    logic [31:0]         w_off;
    logic                w_free, w_corner_go, w_norm_go, w_busy;

    // sum of squares
    assign w_s2 = 64'(i_ent.sq[0]) + 64'(i_ent.sq[1]) + 64'(i_ent.sq[2]);

    // one square root step
    assign w_rb = r_r + r_b;
    assign w_ge = (r_x >= w_rb);
    assign w_rn = w_ge ? ((r_r >> 1) + r_b) : (r_r >> 1);

    // divider setup and one quotient bit per lane
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_abs[i] = i_ent.cr[i][ipcg_pkg::CR_W-1]
                     ? 32'(-$signed(i_ent.cr[i])) : i_ent.cr[i][31:0];
            w_num[i] = {1'b0, w_abs[i], 14'd0} + 47'(w_rn[31:1]);
            w_t[i]   = {r_rem[i], r_num[i][14]};
            w_dge[i] = (w_t[i] >= {2'b00, r_len});
            w_qf[i]  = {r_q[i][13:0], w_dge[i]};
        end
    end

    // dot product term and final offset
    assign w_prod = ipcg_pkg::ACC_W'($signed(i_ent.tlc[r_dcnt])) * ipcg_pkg::ACC_W'(r_n[r_dcnt]);
    assign w_off  = r_deg ? 32'd0 : ipcg_pkg::sat32(ipcg_pkg::rnd_shift(64'(r_acc), 14));

    // result scheduling
    assign w_free      = !r_ov || i_m_tready;
    assign w_busy      = (r_st == ST_SQRT) || (r_st == ST_DIV) || (r_st == ST_DOT) ||
                         (r_st == ST_DONE);
    assign w_corner_go = w_free && w_busy && (r_emit < ipcg_pkg::KIND_NORMAL);
    assign w_norm_go   = w_free && (r_st == ST_DONE) && (r_emit == ipcg_pkg::KIND_NORMAL);
    assign o_pop       = w_norm_go;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_emit <= ipcg_pkg::KIND_TLC;
        end else begin
            if (w_corner_go) begin
                r_emit <= r_emit + 3'd1;
            end
            case (r_st)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_st <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    if ((w_s2 == '0) || i_ent.fov_zero) begin
                        r_st <= ST_DONE;
                    end else begin
                        r_st <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (r_cnt == 5'd31) begin
                        r_st <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_cnt == 5'd14) begin
                        r_st <= ST_DOT;
                    end
                end
                ST_DOT: begin
                    if (r_dcnt == 2'd2) begin
                        r_st <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_norm_go) begin
                        r_st   <= ST_IDLE;
                        r_emit <= ipcg_pkg::KIND_TLC;
                    end
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end

    // normal datapath
    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_SUM: begin
                r_deg <= (w_s2 == '0) || i_ent.fov_zero;
                r_x   <= w_s2;
                r_r   <= '0;
                r_b   <= 64'd1 << 62;
                r_cnt <= '0;
                r_acc <= '0;
                for (int i = 0; i < 3; i++) begin
                    r_n[i] <= '0;
                end
            end
            ST_SQRT: begin
                if (w_ge) begin
                    r_x <= r_x - w_rb;
                end
                r_r   <= w_rn;
                r_b   <= r_b >> 2;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_len <= w_rn[31:0];
                    r_cnt <= '0;
                    for (int i = 0; i < 3; i++) begin
                        r_rem[i] <= {1'b0, w_num[i][46:15]};
                        r_num[i] <= w_num[i][14:0];
                        r_q[i]   <= '0;
                    end
                end
            end
            ST_DIV: begin
                r_cnt <= r_cnt + 5'd1;
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= w_dge[i] ? 33'(w_t[i] - {2'b00, r_len}) : w_t[i][32:0];
                    r_num[i] <= r_num[i] << 1;
                    r_q[i]   <= w_qf[i];
                    if (r_cnt == 5'd14) begin
                        if (!i_ent.cr[i][ipcg_pkg::CR_W-1] && (i_ent.cr[i] != '0)) begin
                            r_n[i] <= -$signed({1'b0, w_qf[i]});
                        end else begin
                            r_n[i] <= $signed({1'b0, w_qf[i]});
                        end
                    end
                end
                r_dcnt <= '0;
            end
            ST_DOT: begin
                r_acc  <= r_acc + w_prod;
                r_dcnt <= r_dcnt + 2'd1;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_corner_go || w_norm_go) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_corner_go) begin
            r_kind  <= r_emit;
            r_ox    <= i_ent.corner[r_emit[1:0]][0];
            r_oy    <= i_ent.corner[r_emit[1:0]][1];
            r_oz    <= i_ent.corner[r_emit[1:0]][2];
            r_ooff  <= '0;
            r_odeg  <= r_deg;
            r_olast <= 1'b0;
        end else if (w_norm_go) begin
            r_kind  <= ipcg_pkg::KIND_NORMAL;
            r_ox    <= 32'(r_n[0]);
            r_oy    <= 32'(r_n[1]);
            r_oz    <= 32'(r_n[2]);
            r_ooff  <= w_off;
            r_odeg  <= r_deg;
            r_olast <= 1'b1;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {r_ooff, r_oz, r_oy, r_ox};
    assign o_m_tuser  = {r_odeg, r_kind};
    assign o_m_tlast  = r_olast;

endmodule

/* hw/rtl/ipcg_checker.sv */
module ipcg_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [191:0] i_s_tdata,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [127:0] o_m_tdata,
    input logic [3:0]   o_m_tuser,
    input logic         o_m_tlast,
    input logic         i_cfg_valid,
    input logic         o_cfg_ready,
    input logic [7:0]   i_cfg_index,
    input logic [31:0]  i_cfg_data
);

    // tlast marks the normal and only the normal
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tuser[2:0] == ipcg_pkg::KIND_NORMAL)))
        else $error("tlast and point kind disagree");

    // no kind beyond the normal
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[2:0] <= ipcg_pkg::KIND_NORMAL))
        else $error("point kind out of range");

    // a degenerate plane has a zero normal and offset
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast && o_m_tuser[3]) |-> (o_m_tdata == '0))
        else $error("degenerate normal not zero");

    // stalled transfer holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled transfer changed");

endmodule

bind image_plane_corner_geometry_core ipcg_checker u_ipcg_checker (.*);

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import ipcg_pkg::*;

    localparam int PFB = POS_FRAC_BITS_DEF;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [191:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [127:0] o_m_tdata;
    logic [3:0]   o_m_tuser;
    logic         o_m_tlast;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [7:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    image_plane_corner_geometry_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // one expected output transfer
    typedef struct {
        logic [2:0]  kind;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] offset;
        logic        degen;
        logic        last;
    } t_point;

    // model copy of the geometry registers
    longint unsigned m_spacing_x, m_spacing_y, m_columns, m_rows;

    logic [191:0] plane_q[$];
    t_point       point_q[$];
    int           errors;
    bit           calm;
    bit           cfg_pending;
    bit           cfg_done;
    logic [7:0]   cfg_idx_next;
    logic [31:0]  cfg_data_next;

    always #5 i_clk = ~i_clk;

    // divide with rounding to nearest, ties away from zero
    function automatic longint rnd(input longint v, input int s);
        longint unsigned m;
        m = v < 0 ? longint'(-v) : v;
        m = (m + (64'd1 << (s - 1))) >> s;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // corners, normal and offset of one image plane
    task automatic predict_plane(input logic [191:0] d);
        longint pos[3], rc[3], cc[3], tl[3], ax[3], ay[3], cr[3], nv[3];
        longint fovx, fovy, dsum, v;
        longint unsigned s2, len, m;
        bit degen;
        t_point p;
        logic [31:0] off;
        s2 = 0;
        dsum = 0;
        off = 0;
        for (int i = 0; i < 3; i++) begin
            pos[i] = longint'($signed(d[32*i +: 32]));
            rc[i]  = longint'($signed(d[96 + 16*i +: 16]));
            cc[i]  = longint'($signed(d[144 + 16*i +: 16]));
        end
        fovx = m_columns * m_spacing_x;
        fovy = m_rows * m_spacing_y;
        for (int i = 0; i < 3; i++) begin
            tl[i] = pos[i] - rnd(longint'(m_spacing_x) * (rc[i] + cc[i]), 31 - PFB);
            ax[i] = rnd(fovx * rc[i], 30 - PFB);
            ay[i] = rnd(fovy * cc[i], 30 - PFB);
        end
        cr[0] = rc[1] * cc[2] - rc[2] * cc[1];
        cr[1] = rc[2] * cc[0] - rc[0] * cc[2];
        cr[2] = rc[0] * cc[1] - rc[1] * cc[0];
        for (int i = 0; i < 3; i++) s2 += cr[i] * cr[i];
        degen = (s2 == 0) || (fovx == 0) || (fovy == 0);
        if (degen) begin
            nv = '{0, 0, 0};
        end else begin
            len = root64(s2);
            for (int i = 0; i < 3; i++) begin
                v = -cr[i];
                m = v < 0 ? longint'(-v) : v;
                m = ((m << 14) + (len >> 1)) / len;
                nv[i] = v < 0 ? -longint'(m) : longint'(m);
            end
            for (int i = 0; i < 3; i++) dsum += tl[i] * nv[i];
            off = clip32(rnd(dsum, 14));
        end
        for (int k = 0; k < 4; k++) begin
            p.kind   = k[2:0];
            p.x      = clip32(tl[0] + (k[0] ? ax[0] : 0) + (k[1] ? ay[0] : 0));
            p.y      = clip32(tl[1] + (k[0] ? ax[1] : 0) + (k[1] ? ay[1] : 0));
            p.z      = clip32(tl[2] + (k[0] ? ax[2] : 0) + (k[1] ? ay[2] : 0));
            p.offset = 0;
            p.degen  = degen;
            p.last   = 1'b0;
            point_q.push_back(p);
        end
        p.kind   = KIND_NORMAL;
        p.x      = clip32(nv[0]);
        p.y      = clip32(nv[1]);
        p.z      = clip32(nv[2]);
        p.offset = off;
        p.degen  = degen;
        p.last   = 1'b1;
        point_q.push_back(p);
    endtask

    function automatic logic [15:0] rnd_cos();
        case ($urandom_range(0, 5))
            0: return 16'(16384);
            1: return -16'(16384);
            2: return 16'($urandom);
            3: return 16'(0);
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic logic [31:0] rnd_pos();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
        endcase
    endfunction

    function automatic logic [191:0] pack_plane(input logic [31:0] px, py, pz,
                                                input logic [15:0] rx, ry, rz,
                                                input logic [15:0] cx, cy, cz);
        return {cz, cy, cx, rz, ry, rx, pz, py, px};
    endfunction

    // build a unit-ish orthogonal pair from axis permutations with random signs
    function automatic logic [191:0] plane_axes();
        logic [15:0] a[3], b[3];
        int ia, ib;
        ia = $urandom_range(0, 2);
        ib = (ia + $urandom_range(1, 2)) % 3;
        for (int i = 0; i < 3; i++) begin
            a[i] = 0;
            b[i] = 0;
        end
        a[ia] = $urandom_range(0, 1) ? 16'(16384) : -16'(16384);
        b[ib] = $urandom_range(0, 1) ? 16'(16384) : -16'(16384);
        return pack_plane(rnd_pos(), rnd_pos(), rnd_pos(), a[0], a[1], a[2], b[0], b[1], b[2]);
    endfunction

    // slave side driver
    int s_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            s_gap <= 0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (i_s_tvalid) predict_plane(i_s_tdata);
            if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                s_gap <= $urandom_range(0, 14);
                i_s_tvalid <= 1'b0;
            end else if (plane_q.size() != 0) begin
                i_s_tdata <= plane_q.pop_front();
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // master side monitor with random stalls
    int m_gap;
    always @(posedge i_clk) begin
        t_point e;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            m_gap <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (point_q.size() == 0) begin
                    $display("%0t: unexpected transfer x=%h", $time, o_m_tdata[31:0]);
                    errors++;
                end else begin
                    e = point_q.pop_front();
                    if (o_m_tuser[2:0] !== e.kind || o_m_tdata[31:0] !== e.x ||
                        o_m_tdata[63:32] !== e.y || o_m_tdata[95:64] !== e.z ||
                        o_m_tdata[127:96] !== e.offset || o_m_tuser[3] !== e.degen ||
                        o_m_tlast !== e.last) begin
                        $display("%0t: mismatch exp kind=%0d x=%h y=%h z=%h off=%h deg=%b last=%b",
                                 $time, e.kind, e.x, e.y, e.z, e.offset, e.degen, e.last);
                        $display("%0t:          got kind=%0d x=%h y=%h z=%h off=%h deg=%b last=%b",
                                 $time, o_m_tuser[2:0], o_m_tdata[31:0], o_m_tdata[63:32],
                                 o_m_tdata[95:64], o_m_tdata[127:96], o_m_tuser[3], o_m_tlast);
                        errors++;
                    end
                end
            end
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                i_m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_gap <= $urandom_range(0, 14);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // config channel driver, one transfer per request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
            i_cfg_index <= '0;
            i_cfg_data  <= '0;
            cfg_done    <= 1'b0;
        end else if (i_cfg_valid) begin
            if (o_cfg_ready) begin
                i_cfg_valid <= 1'b0;
                cfg_done    <= 1'b1;
            end
        end else if (cfg_pending && !cfg_done) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= cfg_idx_next;
            i_cfg_data  <= cfg_data_next;
        end else if (!cfg_pending) begin
            cfg_done <= 1'b0;
        end
    end

    task automatic wait_idle();
        while (plane_q.size() != 0 || i_s_tvalid || point_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        cfg_idx_next  = idx;
        cfg_data_next = val;
        cfg_pending   = 1'b1;
        while (!cfg_done) @(posedge i_clk);
        cfg_pending = 1'b0;
        while (cfg_done) @(posedge i_clk);
        case (idx)
            REG_SPACING_X: m_spacing_x = val & 32'h1f_ffff;
            REG_SPACING_Y: m_spacing_y = val & 32'h1f_ffff;
            REG_COLUMNS:   m_columns   = val & 32'hffff;
            REG_ROWS:      m_rows      = val & 32'hffff;
            default: ;
        endcase
    endtask

    task automatic random_planes(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) != 0) plane_q.push_back(plane_axes());
            else plane_q.push_back(pack_plane(rnd_pos(), rnd_pos(), rnd_pos(), rnd_cos(),
                                              rnd_cos(), rnd_cos(), rnd_cos(), rnd_cos(),
                                              rnd_cos()));
        end
    endtask

    // stimulus
    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_s_tdata = '0;
        errors = 0;
        calm = 1'b0;
        cfg_pending = 1'b0;
        m_spacing_x = SPACING_RST;
        m_spacing_y = SPACING_RST;
        m_columns = PIXELS_RST;
        m_rows = PIXELS_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, orthogonal axes, degenerate cross product
        plane_q.push_back(pack_plane(0, 0, 0, 16384, 0, 0, 0, 16384, 0));
        plane_q.push_back(pack_plane(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                     16384, 0, 0, 0, 0, -16'(16384)));
        plane_q.push_back(pack_plane(32'h8000_0000, 32'h7fff_ffff, 0,
                                     16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
        plane_q.push_back(pack_plane(100, 200, 300, 16384, 0, 0, 16384, 0, 0));
        plane_q.push_back(pack_plane(0, 0, 0, 0, 0, 0, 0, 0, 0));
        plane_q.push_back(pack_plane(32'hffff_ffff, 1, 32'hffff_ffff,
                                     16'hffff, 16'h8000, 16'hffff, 16'h7fff, 16'hffff, 1));
        plane_q.push_back(pack_plane(5000, -5000, 1234, 11585, 11585, 0, -11585, 11585, 0));
        random_planes(8);
        wait_idle();

        // max geometry, then zero spacing and unused index
        write_reg(REG_SPACING_X, 32'h1f_ffff);
        write_reg(REG_SPACING_Y, 32'h10_0000);
        write_reg(REG_COLUMNS, 32'hffff);
        write_reg(REG_ROWS, 32'hffff);
        random_planes(30);
        wait_idle();
        write_reg(REG_SPACING_X, 32'hffe0_0000);
        write_reg(8'd7, 32'h1234);
        random_planes(15);
        wait_idle();

        // minimal geometry
        write_reg(REG_SPACING_X, 1);
        write_reg(REG_SPACING_Y, 1);
        write_reg(REG_COLUMNS, 1);
        write_reg(REG_ROWS, 1);
        random_planes(30);
        wait_idle();

        // random settings, last phase without random gaps or stalls
        for (int ph = 0; ph < 3; ph++) begin
            write_reg(REG_SPACING_X, $urandom);
            write_reg(REG_SPACING_Y, $urandom_range(1, 1 << 20));
            write_reg(REG_COLUMNS, $urandom_range(1, 1024));
            write_reg(REG_ROWS, $urandom);
            if (ph == 2) calm = 1'b1;
            random_planes(25);
            wait_idle();
        end

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
